// File: rtl/core/fpiw_pkg.sv
`timescale 1ns / 1ps

package fpiw_pkg;

  localparam int DefMaxDims   = 4;
  localparam int DefIndexBits = 16;
  localparam int DefDigitBits = 8;

  localparam int PackedDims = 4;
  localparam int SizeBits   = 8;
  localparam int StrideBits = 16;
  localparam int FieldBits  = 16;
  localparam int NumDimBits = 3;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 64;

  localparam int InDataBits  = 8;
  localparam int OutDataBits = 3 * FieldBits;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_NUM_DIMS  = 3'd0,
    REG_DIM_SIZES = 3'd1,
    REG_STRIDES_A = 3'd2,
    REG_STRIDES_B = 3'd3,
    REG_BASE_A    = 3'd4,
    REG_BASE_B    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic step;
    logic restart;
    logic done;
  } cell_ctrl_t;

endpackage

// File: rtl/core/fpiw_cell.sv
`timescale 1ns / 1ps

module fpiw_cell #(
  parameter int INDEX_BITS = fpiw_pkg::DefIndexBits,
  parameter int DIGIT_BITS = fpiw_pkg::DefDigitBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpiw_pkg::cell_ctrl_t            ctrl_i,
  input  logic                            active_i,
  input  logic [fpiw_pkg::SizeBits-1:0]   size_i,
  input  logic [fpiw_pkg::StrideBits-1:0] stride_a_i,
  input  logic [fpiw_pkg::StrideBits-1:0] stride_b_i,
  input  logic                            carry_i,
  input  logic [INDEX_BITS-1:0]           delta_a_i,
  input  logic [INDEX_BITS-1:0]           delta_b_i,
  output logic                            carry_o,
  output logic [INDEX_BITS-1:0]           delta_a_o,
  output logic [INDEX_BITS-1:0]           delta_b_o
);
  import fpiw_pkg::*;

  localparam int CmpBits  = ((DIGIT_BITS > SizeBits) ? DIGIT_BITS : SizeBits) + 1;
  localparam int ProdBits = SizeBits + StrideBits;

  logic [DIGIT_BITS-1:0] dig_q, dig_d, dig_cur;
  logic [SizeBits-1:0]   size_eff, size_m1;
  logic [ProdBits-1:0]   prod_a, prod_b;
  logic [INDEX_BITS-1:0] pull_a, pull_b;
  logic                  wrap, step_here;

  always_comb begin
    dig_cur   = ctrl_i.restart ? '0 : dig_q;
    size_eff  = (size_i == '0) ? SizeBits'(1) : size_i;
    size_m1   = size_eff - SizeBits'(1);
    wrap      = ((CmpBits'(dig_cur) + CmpBits'(1)) >= CmpBits'(size_eff)) || (dig_cur == '1);
    prod_a    = ProdBits'(size_m1) * ProdBits'(stride_a_i);
    prod_b    = ProdBits'(size_m1) * ProdBits'(stride_b_i);
    pull_a    = INDEX_BITS'(prod_a);
    pull_b    = INDEX_BITS'(prod_b);
    step_here = carry_i & active_i;
    carry_o   = active_i ? (carry_i & wrap) : carry_i;
    delta_a_o = delta_a_i;
    delta_b_o = delta_b_i;
    if (step_here) begin
      if (wrap) begin
        delta_a_o = delta_a_i - pull_a;
        delta_b_o = delta_b_i - pull_b;
      end else begin
        delta_a_o = delta_a_i + INDEX_BITS'(stride_a_i);
        delta_b_o = delta_b_i + INDEX_BITS'(stride_b_i);
      end
    end
  end

  always_comb begin
    dig_d = dig_q;
    if (ctrl_i.step) begin
      if (ctrl_i.done) begin
        dig_d = '0;
      end else if (step_here) begin
        dig_d = wrap ? '0 : dig_cur + DIGIT_BITS'(1);
      end else begin
        dig_d = dig_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

endmodule

// File: rtl/core/factor_product_index_walker.sv
`timescale 1ns / 1ps

// A word accepted at one clock edge shows its result on the master side from
// the next cycle on. One word per cycle, while the master side takes or is empty,
// set by the carry chain that runs combinationally through the row of digit cells.
// Reset clears the walk (digits, offsets, entry count) and loads every
// configuration register with its default; no clearing pass is needed.
module factor_product_index_walker #(
  parameter int MAX_DIMS   = fpiw_pkg::DefMaxDims,
  parameter int INDEX_BITS = fpiw_pkg::DefIndexBits,
  parameter int DIGIT_BITS = fpiw_pkg::DefDigitBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fpiw_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [fpiw_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // restart at bit 0, zeros above.
  input  logic [fpiw_pkg::InDataBits-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_index [15:0], index_a [31:16], index_b [47:32].
  output logic [fpiw_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import fpiw_pkg::*;

  logic [NumDimBits-1:0]       num_dims_q;
  logic [PackedDims*SizeBits-1:0]   dim_sizes_q;
  logic [PackedDims*StrideBits-1:0] strides_a_q, strides_b_q;
  logic [FieldBits-1:0]        base_a_q, base_b_q;

  logic [INDEX_BITS-1:0] off_a_q, off_b_q, entry_q;
  logic [INDEX_BITS-1:0] off_a_cur, off_b_cur, entry_cur;
  logic [INDEX_BITS-1:0] off_a_d, off_b_d, entry_d;

  logic                   m_valid_q;
  logic [OutDataBits-1:0] m_data_q;
  logic                   m_last_q;

  logic       accept, restart, done;
  cell_ctrl_t ctrl;

  logic [MAX_DIMS:0]     carry;
  logic [INDEX_BITS-1:0] delta_a [MAX_DIMS+1];
  logic [INDEX_BITS-1:0] delta_b [MAX_DIMS+1];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = accept && s_axis_tdata[0];

  assign carry[0]   = 1'b1;
  assign delta_a[0] = '0;
  assign delta_b[0] = '0;
  assign done       = carry[MAX_DIMS];

  assign ctrl.step    = accept;
  assign ctrl.restart = restart;
  assign ctrl.done    = done;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    logic [SizeBits-1:0]   size_d;
    logic [StrideBits-1:0] sa_d, sb_d;
    logic                  active_d;

    if (d < PackedDims) begin : g_packed
      assign size_d = dim_sizes_q[d*SizeBits +: SizeBits];
      assign sa_d   = strides_a_q[d*StrideBits +: StrideBits];
      assign sb_d   = strides_b_q[d*StrideBits +: StrideBits];
    end else begin : g_unpacked
      assign size_d = SizeBits'(1);
      assign sa_d   = '0;
      assign sb_d   = '0;
    end

    if (d == 0) begin : g_first
      assign active_d = 1'b1;
    end else begin : g_rest
      assign active_d = num_dims_q > NumDimBits'(d);
    end

    fpiw_cell #(
      .INDEX_BITS(INDEX_BITS),
      .DIGIT_BITS(DIGIT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .active_i  (active_d),
      .size_i    (size_d),
      .stride_a_i(sa_d),
      .stride_b_i(sb_d),
      .carry_i   (carry[d]),
      .delta_a_i (delta_a[d]),
      .delta_b_i (delta_b[d]),
      .carry_o   (carry[d+1]),
      .delta_a_o (delta_a[d+1]),
      .delta_b_o (delta_b[d+1])
    );
  end

  always_comb begin
    off_a_cur = restart ? '0 : off_a_q;
    off_b_cur = restart ? '0 : off_b_q;
    entry_cur = restart ? '0 : entry_q;
    off_a_d   = off_a_q;
    off_b_d   = off_b_q;
    entry_d   = entry_q;
    if (accept) begin
      if (done) begin
        off_a_d = '0;
        off_b_d = '0;
        entry_d = '0;
      end else begin
        off_a_d = off_a_cur + delta_a[MAX_DIMS];
        off_b_d = off_b_cur + delta_b[MAX_DIMS];
        entry_d = entry_cur + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_a_q <= '0;
      off_b_q <= '0;
      entry_q <= '0;
    end else begin
      off_a_q <= off_a_d;
      off_b_q <= off_b_d;
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= NumDimBits'(1);
      dim_sizes_q <= {PackedDims{SizeBits'(1)}};
      strides_a_q <= '0;
      strides_b_q <= '0;
      base_a_q    <= '0;
      base_b_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_DIMS:  num_dims_q  <= cfg_data_i[NumDimBits-1:0];
        REG_DIM_SIZES: dim_sizes_q <= cfg_data_i[PackedDims*SizeBits-1:0];
        REG_STRIDES_A: strides_a_q <= cfg_data_i[PackedDims*StrideBits-1:0];
        REG_STRIDES_B: strides_b_q <= cfg_data_i[PackedDims*StrideBits-1:0];
        REG_BASE_A:    base_a_q    <= cfg_data_i[FieldBits-1:0];
        REG_BASE_B:    base_b_q    <= cfg_data_i[FieldBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {base_b_q + FieldBits'(off_b_cur),
                   base_a_q + FieldBits'(off_a_cur),
                   FieldBits'(entry_cur)};
      m_last_q <= done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && done |=> entry_q == '0 && off_a_q == '0 && off_b_q == '0)
    else $error("walk not cleared after its last word");

  a_entry_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !done && !restart |=> entry_q == $past(entry_q) + INDEX_BITS'(1))
    else $error("entry count did not advance by one");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(entry_q) && $stable(off_a_q) && $stable(off_b_q))
    else $error("walk state moved without an accepted word");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_valid_q && m_last_q == $past(done))
    else $error("accepted word did not produce its result");
`endif

endmodule
